// ===== hw/rtl/nswd_pkg.sv =====
// Package for the sample widener: type codes, status codes, the result type and a bit-position helper.
// It depends on nothing else. The converter module and the top level use it.
`timescale 1ns / 1ps
`default_nettype none
package nswd_pkg;

  localparam logic [7:0] TypeI8     = 8'd1;
  localparam logic [7:0] TypeU8     = 8'd2;
  localparam logic [7:0] TypeI16    = 8'd3;
  localparam logic [7:0] TypeU16    = 8'd4;
  localparam logic [7:0] TypeI32    = 8'd5;
  localparam logic [7:0] TypeU32    = 8'd6;
  localparam logic [7:0] TypeSingle = 8'd7;
  localparam logic [7:0] TypeDouble = 8'd9;
  localparam logic [7:0] TypeI64    = 8'd12;
  localparam logic [7:0] TypeU64    = 8'd13;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StBadType = 2'd1;
  localparam logic [1:0] StInexact = 2'd2;

  localparam int unsigned SigBits = 53;

  typedef struct packed {
    logic [63:0] bits;
    logic [1:0]  status;
  } result_t;

  // Returns the index of the highest set bit, from a 64-bit priority encoder.
  function automatic logic [5:0] msb_pos64(input logic [63:0] v);
    logic [5:0] p;
    p = '0;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) p = 6'(i);
    end
    return p;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/nswd_convert.sv =====
// Combinational conversion of one sample to double bits and a status code.
// Depends on nswd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module nswd_convert (
  input  wire logic [7:0]       elem_type_i,
  input  wire logic [63:0]      raw_sample_i,
  output nswd_pkg::result_t     result_o
);

  logic        neg;
  logic        is_int;
  logic [63:0] mag;
  logic [5:0]  pos;
  logic [63:0] sig;
  logic        lost;
  logic [63:0] ibits;
  logic [63:0] fbits;
  logic [31:0] f;
  logic [5:0]  fpos;
  logic [63:0] ffrac;

  always_comb begin
    neg    = 1'b0;
    is_int = 1'b1;
    mag    = '0;
    unique case (elem_type_i)
      nswd_pkg::TypeI8: begin
        neg = raw_sample_i[7];
        mag = {56'd0, neg ? 8'(-raw_sample_i[7:0]) : raw_sample_i[7:0]};
      end
      nswd_pkg::TypeU8:  mag = {56'd0, raw_sample_i[7:0]};
      nswd_pkg::TypeI16: begin
        neg = raw_sample_i[15];
        mag = {48'd0, neg ? 16'(-raw_sample_i[15:0]) : raw_sample_i[15:0]};
      end
      nswd_pkg::TypeU16: mag = {48'd0, raw_sample_i[15:0]};
      nswd_pkg::TypeI32: begin
        neg = raw_sample_i[31];
        mag = {32'd0, neg ? 32'(-raw_sample_i[31:0]) : raw_sample_i[31:0]};
      end
      nswd_pkg::TypeU32: mag = {32'd0, raw_sample_i[31:0]};
      nswd_pkg::TypeI64: begin
        neg = raw_sample_i[63];
        mag = neg ? -raw_sample_i : raw_sample_i;
      end
      nswd_pkg::TypeU64: mag = raw_sample_i;
      default: is_int = 1'b0;
    endcase
  end

  // Integer path: left-justify so the leading one lands on bit 63, then take 52 bits.
  always_comb begin
    pos   = nswd_pkg::msb_pos64(mag);
    sig   = mag << (6'd63 - pos);
    // Bits shifted below the 53-bit window are those in sig[10:0].
    lost  = |sig[10:0];
    ibits = (mag == '0) ? '0 :
            {neg, 11'(pos) + 11'd1023, sig[62:11]};
  end

  // Single path.
  always_comb begin
    f     = raw_sample_i[31:0];
    fpos  = nswd_pkg::msb_pos64({41'd0, f[22:0]});
    ffrac = {41'd0, f[22:0]} << (6'd52 - fpos);
    if (f[30:23] == 8'hFF) begin
      fbits = {f[31], 11'h7FF, (f[22:0] != '0), f[21:0], 29'd0};
      if (f[22:0] != '0) fbits[51] = 1'b1;
      fbits[50:29] = f[21:0];
    end else if (f[30:23] == 8'h00) begin
      if (f[22:0] == '0) fbits = {f[31], 63'd0};
      else fbits = {f[31], 11'(fpos) + 11'd874, ffrac[51:0]};
    end else begin
      fbits = {f[31], {3'd0, f[30:23]} + 11'd896, f[22:0], 29'd0};
    end
  end

  always_comb begin
    result_o.bits   = '0;
    result_o.status = nswd_pkg::StOk;
    if (is_int) begin
      if (lost) result_o.status = nswd_pkg::StInexact;
      else result_o.bits = ibits;
    end else if (elem_type_i == nswd_pkg::TypeSingle) begin
      result_o.bits = fbits;
    end else if (elem_type_i == nswd_pkg::TypeDouble) begin
      result_o.bits = raw_sample_i;
    end else begin
      result_o.status = nswd_pkg::StBadType;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/numeric_sample_widen_to_double.sv =====
// Top level of the sample widener: input register, converter, result register.
// Depends on nswd_pkg and nswd_convert.
//
// Usage: an input beat carries elem_type_i and raw_sample_i on in_valid_i/in_ready_o.
// The sample is registered, converted by combinational logic, and
// the result is registered and offered on out_valid_o/out_ready_i with double_bits_o
// and status_o. An accepted beat is held in the input register, and its result is
// captured in the result register when that register is empty or being drained.
// Throughput is one beat per cycle while out_ready_i is high, as both stages
// advance whenever the next stage is empty or being drained.
// If the receiver stalls, the result register holds, the input register fills
// behind it, and in_ready_o falls only when both are occupied; no beat is lost.
// Reset clears both valid flags; the block accepts beats immediately after.
// Unknown type codes give zero bits and status 1; 64-bit integers that would
// lose low bits give zero bits and status 2.
`timescale 1ns / 1ps
`default_nettype none
module numeric_sample_widen_to_double (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output      logic        in_ready_o,
  input  wire logic [7:0]  elem_type_i,
  input  wire logic [63:0] raw_sample_i,
  output      logic        out_valid_o,
  input  wire logic        out_ready_i,
  output      logic [63:0] double_bits_o,
  output      logic [1:0]  status_o
);

  logic        in_vld_q;
  logic [7:0]  type_q;
  logic [63:0] raw_q;
  logic        out_vld_q;
  nswd_pkg::result_t res_d, res_q;
  logic        out_adv;
  logic        in_adv;

  nswd_convert u_convert (
    .elem_type_i (type_q),
    .raw_sample_i(raw_q),
    .result_o    (res_d)
  );

  assign out_adv    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || out_adv;
  assign in_adv     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_ready_o) in_vld_q <= in_valid_i;
      if (out_adv) out_vld_q <= 1'b1;
      else if (out_ready_i) out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_adv) begin
      type_q <= elem_type_i;
      raw_q  <= raw_sample_i;
    end
    if (out_adv) res_q <= res_d;
  end

  assign out_valid_o   = out_vld_q;
  assign double_bits_o = res_q.bits;
  assign status_o      = res_q.status;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_ready_i |=> out_vld_q && $stable(res_q))
    else $error("result changed while stalled");
  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_adv |=> in_vld_q)
    else $error("accepted beat not held in input register");
  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_adv |=> out_vld_q)
    else $error("converted beat not presented");
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && res_q.status != nswd_pkg::StOk |-> res_q.bits == '0)
    else $error("error result with nonzero bits");

endmodule
`default_nettype wire

// ===== test/nswd_checker.sv =====
// Checker for the sample widener: watches both channels, predicts each result
// from the input beat and compares it with the output beat. Depends on nswd_pkg.
`timescale 1ns / 1ps
module nswd_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_o,
  input  logic [7:0]  elem_type_i,
  input  logic [63:0] raw_sample_i,
  input  logic        out_valid_o,
  input  logic        out_ready_i,
  input  logic [63:0] double_bits_o,
  input  logic [1:0]  status_o,
  output int          errors_o,
  output int          pending_o,
  output int          results_o
);

  typedef struct packed {
    logic [63:0] bits;
    logic [1:0]  status;
  } widened_t;

  widened_t widened_q[$];

  function automatic int unsigned top_bit(input logic [63:0] v);
    int unsigned n;
    n = 0;
    for (int i = 0; i < 64; i++) if (v[i]) n = i + 1;
    return n;
  endfunction

  function automatic widened_t widen_int(input logic neg, input logic [63:0] mag);
    widened_t r;
    int unsigned len;
    logic [63:0] sig;
    logic [63:0] low_mask;
    len = top_bit(mag);
    r.status = nswd_pkg::StOk;
    r.bits = '0;
    if (len == 0) return r;
    if (len > 53) begin
      low_mask = (64'd1 << (len - 53)) - 64'd1;
      if ((mag & low_mask) != 0) begin
        r.status = nswd_pkg::StInexact;
        return r;
      end
      sig = mag >> (len - 53);
    end else begin
      sig = mag << (53 - len);
    end
    r.bits = {neg, 11'(len - 1 + 1023), sig[51:0]};
    return r;
  endfunction

  function automatic logic [63:0] widen_single(input logic [31:0] f);
    logic [7:0]  e;
    logic [63:0] frac;
    int unsigned p;
    e = f[30:23];
    frac = {41'd0, f[22:0]};
    if (e == 8'hff) begin
      if (frac == 0) return {f[31], 11'h7ff, 52'd0};
      // The payload keeps its place; only the quiet bit is forced.
      return {f[31], 11'h7ff, 1'b1, f[21:0], 29'd0};
    end
    if (e == 0) begin
      if (frac == 0) return {f[31], 63'd0};
      p = top_bit(frac) - 1;
      frac = frac << (52 - p);
      return {f[31], 11'(p + 1023 - 149), frac[51:0]};
    end
    return {f[31], 11'(e + 896), f[22:0], 29'd0};
  endfunction

  function automatic widened_t predict_widen(input logic [7:0] t, input logic [63:0] raw);
    widened_t r;
    r.bits = '0;
    r.status = nswd_pkg::StOk;
    case (t)
      nswd_pkg::TypeI8:
        r = widen_int(raw[7], raw[7] ? 64'(-$signed(raw[7:0])) : 64'(raw[7:0]));
      nswd_pkg::TypeU8:     r = widen_int(1'b0, 64'(raw[7:0]));
      nswd_pkg::TypeI16:
        r = widen_int(raw[15], raw[15] ? 64'(-$signed(raw[15:0])) : 64'(raw[15:0]));
      nswd_pkg::TypeU16:    r = widen_int(1'b0, 64'(raw[15:0]));
      nswd_pkg::TypeI32:
        r = widen_int(raw[31], raw[31] ? 64'(-$signed(raw[31:0])) : 64'(raw[31:0]));
      nswd_pkg::TypeU32:    r = widen_int(1'b0, 64'(raw[31:0]));
      nswd_pkg::TypeI64:    r = widen_int(raw[63], raw[63] ? -raw : raw);
      nswd_pkg::TypeU64:    r = widen_int(1'b0, raw);
      nswd_pkg::TypeSingle: r.bits = widen_single(raw[31:0]);
      nswd_pkg::TypeDouble: r.bits = raw;
      default:              r.status = nswd_pkg::StBadType;
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    widened_t w;
    if (!rst_ni) begin
      errors_o  <= 0;
      results_o <= 0;
    end else begin
      if (in_valid_i && in_ready_o)
        widened_q = {widened_q, predict_widen(elem_type_i, raw_sample_i)};
      if (out_valid_o && out_ready_i) begin
        results_o <= results_o + 1;
        if (widened_q.size() == 0) begin
          $display("%0t: result beat with nothing expected: bits %h status %0d",
                   $time, double_bits_o, status_o);
          errors_o <= errors_o + 1;
        end else begin
          w = widened_q.pop_front();
          if (w.bits !== double_bits_o || w.status !== status_o) begin
            $display("%0t: mismatch: expected bits %h status %0d, got bits %h status %0d",
                     $time, w.bits, w.status, double_bits_o, status_o);
            errors_o <= errors_o + 1;
          end
        end
      end
    end
  end

  // The queue is updated at the rising edge, so count after it settles.
  always @(negedge clk_i) pending_o = widened_q.size();
endmodule

// ===== test/tb_numeric_sample_widen_to_double.sv =====
// Testbench top for the sample widener: clock, reset, directed and random beats,
// random output stalls and the verdict. Depends on nswd_pkg, the RTL and nswd_checker.
`timescale 1ns / 1ps
module tb_numeric_sample_widen_to_double;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  elem_type_i = '0;
  logic [63:0] raw_sample_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [63:0] double_bits_o;
  logic [1:0]  status_o;
  int          errors, pending, results;
  int          cycles = 0;
  logic        calm = 1'b0;

  localparam int CycleLimit = 200000;
  localparam logic [7:0] KnownTypes [10] = '{
    nswd_pkg::TypeI8, nswd_pkg::TypeU8, nswd_pkg::TypeI16, nswd_pkg::TypeU16,
    nswd_pkg::TypeI32, nswd_pkg::TypeU32, nswd_pkg::TypeSingle, nswd_pkg::TypeDouble,
    nswd_pkg::TypeI64, nswd_pkg::TypeU64};

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  numeric_sample_widen_to_double uut (.*);

  nswd_checker checker_i (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .elem_type_i, .raw_sample_i,
    .out_valid_o, .out_ready_i, .double_bits_o, .status_o,
    .errors_o(errors), .pending_o(pending), .results_o(results)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("[numeric_sample_widen_to_double] ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) out_ready_i <= calm || ($urandom_range(99) >= 22);

  // Valid is dropped only for idle cycles, so back-to-back beats keep it high.
  task automatic send_beat(input logic [7:0] t, input logic [63:0] raw);
    while (!calm && $urandom_range(99) < 22) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    elem_type_i  <= t;
    raw_sample_i <= raw;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Integers with a mix of shifted, inverted and full-width magnitudes so both the exact and inexact
  // 64-bit paths are hit; floats mixed with special exponents.
  function automatic logic [63:0] shaped_sample(input logic [7:0] t);
    logic [63:0] v;
    v = rand64();
    case ($urandom_range(5))
      0: v = v >> $urandom_range(63);
      1: v = v << $urandom_range(63);
      2: v = ~(v >> $urandom_range(63));
      default: ;
    endcase
    if (t == nswd_pkg::TypeSingle && $urandom_range(3) == 0)
      v[30:23] = $urandom_range(1) ? 8'hff : 8'h00;
    if (t == nswd_pkg::TypeDouble && $urandom_range(3) == 0)
      v[62:52] = $urandom_range(1) ? 11'h7ff : 11'h000;
    return v;
  endfunction

  initial begin
    logic [7:0] t;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Directed: extremes of each integer type, float specials, bad codes.
    send_beat(nswd_pkg::TypeI8, 64'hffff_ffff_ffff_ff80);
    send_beat(nswd_pkg::TypeI8, 64'h7f);
    send_beat(nswd_pkg::TypeU8, 64'hff);
    send_beat(nswd_pkg::TypeI16, 64'h8000);
    send_beat(nswd_pkg::TypeU16, 64'hffff);
    send_beat(nswd_pkg::TypeI32, 64'h8000_0000);
    send_beat(nswd_pkg::TypeU32, 64'hffff_ffff_0000_0000);
    send_beat(nswd_pkg::TypeI64, 64'h8000_0000_0000_0000);
    send_beat(nswd_pkg::TypeI64, 64'hffff_ffff_ffff_ffff);
    send_beat(nswd_pkg::TypeU64, 64'hffff_ffff_ffff_ffff);
    send_beat(nswd_pkg::TypeU64, 64'h001f_ffff_ffff_ffff);
    send_beat(nswd_pkg::TypeU64, 64'h0020_0000_0000_0001);
    send_beat(nswd_pkg::TypeU64, 64'h0);
    send_beat(nswd_pkg::TypeSingle, 64'h7f80_0000);
    send_beat(nswd_pkg::TypeSingle, 64'hff80_0000);
    send_beat(nswd_pkg::TypeSingle, 64'h7f80_0001);
    send_beat(nswd_pkg::TypeSingle, 64'hffc0_0000);
    send_beat(nswd_pkg::TypeSingle, 64'h0000_0001);
    send_beat(nswd_pkg::TypeSingle, 64'h807f_ffff);
    send_beat(nswd_pkg::TypeSingle, 64'h8000_0000);
    send_beat(nswd_pkg::TypeSingle, 64'h7f7f_ffff);
    send_beat(nswd_pkg::TypeDouble, 64'hffff_ffff_ffff_ffff);
    send_beat(8'd0, 64'h1234);
    send_beat(8'd255, 64'h1);
    send_beat(8'd8, 64'h1);
    for (int i = 0; i < 1600; i++) begin
      calm = (i >= 700 && i < 900);
      if ($urandom_range(19) == 0) t = 8'($urandom);
      else t = KnownTypes[$urandom_range(9)];
      send_beat(t, shaped_sample(t));
    end
    in_valid_i <= 1'b0;
    calm = 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    $display("Sent 1625 samples over all element types and bad codes, %0d results checked.",
             results);
    if (errors == 0 && pending == 0) begin
      $display("[numeric_sample_widen_to_double] OK");
    end else begin
      $display("[numeric_sample_widen_to_double] ERROR");
    end
    $finish;
  end
endmodule

// ===== numeric_sample_widen_to_double.f =====
hw/rtl/nswd_pkg.sv
hw/rtl/nswd_convert.sv
hw/rtl/numeric_sample_widen_to_double.sv
test/nswd_checker.sv
test/tb_numeric_sample_widen_to_double.sv
